// File: rtl/hash_product_exponent_accumulator_defines.svh
// Assertion macros for the hash product exponent accumulator.
`ifndef HASH_PRODUCT_EXPONENT_ACCUMULATOR_DEFINES_SVH
`define HASH_PRODUCT_EXPONENT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HPEA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hpea: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HPEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hpea: next-cycle check failed");

`endif

// File: rtl/hpea_pkg.sv
// Package: shared types and constants of the hash product exponent accumulator.
`default_nettype none
package hpea_pkg;

	localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
	localparam logic [7:0]  PAD_BYTE     = 8'hFF;
	localparam logic [2:0]  GATHER_BYTES = 3'd4;
	localparam logic [31:0] ZERO_BYTE_EXP = 32'd8;

	typedef struct packed {
		logic [7:0] hash_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] exponent;
		logic [31:0] mantissa;
	} out_item_t;

	// One classified hash: exponent increment before the product fixup,
	// and the normalized gathered word.
	typedef struct packed {
		logic [31:0] delta;
		logic [31:0] word;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// File: rtl/hpea_front.sv
// Front end: per-byte hash scan, gathering, padding and normalization.
`default_nettype none
module hpea_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire hpea_pkg::in_item_t item,
	output logic                  work_push,
	output hpea_pkg::work_t       work
);

	logic        at_start_q;
	logic        in_lz_q;
	logic [2:0]  cnt_q;
	logic [31:0] word_q;
	logic [31:0] delta_q;

	logic        lead;
	logic        take_b;
	logic [31:0] delta_cur;
	logic [31:0] delta_b;
	logic [31:0] word_n;
	logic [2:0]  cnt_n;
	logic [31:0] padded;
	logic [2:0]  lz;
	logic        found;

	always_comb begin
		// delta_q is zero between hashes, so the start bump is a select
		delta_cur = at_start_q ? 32'd1 : delta_q;
		lead      = in_lz_q && (item.hash_byte == 8'd0);
		delta_b   = lead ? delta_cur + hpea_pkg::ZERO_BYTE_EXP : delta_cur;
		take_b    = !lead && (cnt_q < hpea_pkg::GATHER_BYTES);
		word_n    = take_b ? {word_q[23:0], item.hash_byte} : word_q;
		cnt_n     = take_b ? cnt_q + 3'd1 : cnt_q;

		case (cnt_n)
			3'd0:    padded = {4{hpea_pkg::PAD_BYTE}};
			3'd1:    padded = {word_n[7:0], {3{hpea_pkg::PAD_BYTE}}};
			3'd2:    padded = {word_n[15:0], {2{hpea_pkg::PAD_BYTE}}};
			3'd3:    padded = {word_n[23:0], hpea_pkg::PAD_BYTE};
			default: padded = word_n;
		endcase

		// top byte is always nonzero here: at most seven shifts
		lz    = 3'd0;
		found = 1'b0;
		for (int i = 31; i >= 24; i--) begin
			if (!found) begin
				if (padded[i]) begin
					found = 1'b1;
				end else begin
					lz = lz + 3'd1;
				end
			end
		end

		work.word  = padded << lz;
		work.delta = delta_b + {29'd0, lz};
		work_push  = take && item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			in_lz_q    <= 1'b1;
			cnt_q      <= 3'd0;
			word_q     <= 32'd0;
			delta_q    <= 32'd0;
		end else if (take) begin
			if (item.last_byte) begin
				at_start_q <= 1'b1;
				in_lz_q    <= 1'b1;
				cnt_q      <= 3'd0;
				word_q     <= 32'd0;
				delta_q    <= 32'd0;
			end else begin
				at_start_q <= 1'b0;
				in_lz_q    <= lead;
				cnt_q      <= cnt_n;
				word_q     <= word_n;
				delta_q    <= delta_b;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/hpea_queue.sv
// Small first-word-fall-through queue between front and back end.
`default_nettype none
module hpea_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr,
	input  wire hpea_pkg::work_t      wr_data,
	input  wire logic                 rd,
	output hpea_pkg::work_t           rd_data,
	output hpea_pkg::queue_status_t   status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0]   CNT_MAX = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);

	hpea_pkg::work_t slot_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [AW:0]     cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign status.full  = (cnt_q == CNT_MAX);
	assign status.empty = (cnt_q == '0);
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_data      = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_MAX) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_MAX) ? '0 : rptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/hpea_back.sv
// Back end: mantissa multiply, renormalization and result register.
`default_nettype none
module hpea_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hpea_pkg::work_t      work,
	input  wire logic                 work_empty,
	output logic                      work_pop,
	input  wire logic                 pop,
	output logic                      empty,
	output hpea_pkg::out_item_t       result
);

	logic [31:0]         exp_q;
	logic [31:0]         mant_q;
	logic                vld_q;
	hpea_pkg::out_item_t res_q;

	logic [63:0] prod;
	logic        top;
	logic [31:0] mant_n;
	logic [31:0] exp_n;

	always_comb begin
		prod     = {32'd0, work.word} * {32'd0, mant_q};
		top      = prod[63];
		mant_n   = top ? prod[63:32] : prod[62:31];
		exp_n    = exp_q + work.delta - {31'd0, top};
		work_pop = !work_empty && (!vld_q || pop);
	end

	assign empty  = !vld_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (work_pop) begin
			res_q.exponent <= exp_n;
			res_q.mantissa <= mant_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= 32'd0;
			mant_q <= hpea_pkg::TOP_BIT;
			vld_q  <= 1'b0;
		end else begin
			if (work_pop) begin
				exp_q  <= exp_n;
				mant_q <= mant_n;
				vld_q  <= 1'b1;
			end else if (pop) begin
				vld_q  <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/hash_product_exponent_accumulator.sv
// Top level of the hash product exponent accumulator.
// Accumulates a running product of hashes, each read as a binary fraction in
// (0,1) padded with one bits, as a negative power-of-two exponent and a
// normalized 32-bit mantissa (top bit always set). One hash byte, most
// significant first, is taken per push transaction; last_byte closes the hash
// and yields exactly one result transaction carrying the updated exponent and
// mantissa; other bytes yield none. Throughput is one byte per clock while
// full is low, including back-to-back single-byte hashes. The front end
// scans bytes, counts leading zero bytes, gathers and pads four bytes and
// normalizes them in the cycle the last byte is pushed; the back end runs
// one 32x32 multiply per hash with the mantissa fed back through a register,
// so one hash per clock is the back end's limit. A QUEUE_DEPTH-entry queue
// decouples the two halves, and a result register lets a new hash finish
// while the previous result still waits: a last byte's work is written into
// the queue at the edge that accepts it and reaches the result ports once the
// result register is free. full rises only when the queue is full because
// results are not being popped. The exponent wraps modulo 2^32.
`default_nettype none
`include "hash_product_exponent_accumulator_defines.svh"
module hash_product_exponent_accumulator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire hpea_pkg::in_item_t   item,
	output logic                      empty,
	input  wire logic                 pop,
	output hpea_pkg::out_item_t       result
);

	logic                    take;
	logic                    work_push;
	logic                    work_pop;
	hpea_pkg::work_t         work_in;
	hpea_pkg::work_t         work_out;
	hpea_pkg::queue_status_t q_st;

	// Stall every byte while the queue is full, whether or not it closes a hash.
	assign full = q_st.full;
	assign take = push && !full;

	hpea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.work_push (work_push),
		.work      (work_in)
	);

	hpea_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (work_push),
		.wr_data (work_in),
		.rd      (work_pop),
		.rd_data (work_out),
		.status  (q_st)
	);

	hpea_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (work_out),
		.work_empty (q_st.empty),
		.work_pop   (work_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	// Every shown mantissa is normalized.
	`HPEA_ASSERT_NOW(a_mant_norm, clk, arst_n, !empty, result.mantissa[31])
	// A closed hash lands in the queue.
	`HPEA_ASSERT_NEXT(a_hash_queued, clk, arst_n, take && item.last_byte, !q_st.empty)
	// Queued work moves into a free result register.
	`HPEA_ASSERT_NEXT(a_drain, clk, arst_n, !q_st.empty && (empty || pop), !empty)

endmodule
`default_nettype wire
